// ----- hdl/edfl_pkg.sv -----
// Package for the epoch-marked frontier lists block.
// Holds field widths, op and status codes, the controller state type and the
// command and status structs shared between controller and datapath.
package edfl_pkg;

  localparam int OP_W       = 3;
  localparam int ID_FIELD_W = 12;
  localparam int SLOT_W     = 8;
  localparam int SIZE_W     = 9;
  localparam int STATUS_W   = 2;
  localparam int SYNC_W     = 2;

  localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
  localparam logic [OP_W-1:0] OP_SWAP   = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_CUR = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_NXT = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET  = 3'd5;

  localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd3;

  localparam logic [SYNC_W-1:0] SYNC_NONE   = 2'd0;
  localparam logic [SYNC_W-1:0] SYNC_SINGLE = 2'd1;
  localparam logic [SYNC_W-1:0] SYNC_MULTI  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RM_LREAD,
    S_RM_MREAD,
    S_RM_EVAL,
    S_SWAP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic rm_lread;
    logic rm_mread;
    logic rm_eval;
    logic swap;
    logic resp_load;
    logic clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_empty;
    logic idx_last;
    logic clr_last;
    logic need_clear;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hdl/edfl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module edfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/edfl_ctrl.sv -----
// Controller state machine for the frontier lists block.
// Depends on edfl_pkg; drives the datapath through dp_cmd_t.
module edfl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [edfl_pkg::OP_W-1:0]   in_op,
  output logic                        in_ready,
  input  edfl_pkg::dp_sts_t           sts,
  output edfl_pkg::dp_cmd_t           cmd
);

  import edfl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_op) inside
            OP_PUT, OP_RD_CUR, OP_RD_NXT: state_nxt = S_EVAL;
            OP_SWAP, OP_RESET:            state_nxt = S_SWAP;
            OP_REMOVE:                    state_nxt = sts.cur_empty ? S_SWAP : S_RM_LREAD;
            default:                      state_nxt = S_RESP;
          endcase
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RM_LREAD: begin
        cmd.rm_lread = 1'b1;
        state_nxt    = S_RM_MREAD;
      end
      S_RM_MREAD: begin
        cmd.rm_mread = 1'b1;
        state_nxt    = S_RM_EVAL;
      end
      S_RM_EVAL: begin
        cmd.rm_eval = 1'b1;
        state_nxt   = sts.idx_last ? S_SWAP : S_RM_LREAD;
      end
      S_SWAP: begin
        cmd.swap  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = sts.need_clear ? S_CLEAR : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/edfl_dp.sv -----
// Datapath for the frontier lists block: mark memory, two list memories,
// counts, epoch, clear sweep and the result register. Depends on edfl_pkg
// and edfl_ram.
module edfl_dp #(
  parameter int ID_COUNT   = 4096,
  parameter int LIST_DEPTH = 256,
  parameter int EPOCH_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  edfl_pkg::dp_cmd_t                 cmd,
  output edfl_pkg::dp_sts_t                 sts,
  input  logic [edfl_pkg::OP_W-1:0]         in_op,
  input  logic [edfl_pkg::ID_FIELD_W-1:0]   in_item_id,
  input  logic [edfl_pkg::SLOT_W-1:0]       in_slot,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [edfl_pkg::STATUS_W-1:0]     out_status,
  output logic [edfl_pkg::ID_FIELD_W-1:0]   out_entry_id,
  output logic [edfl_pkg::SIZE_W-1:0]       out_current_size,
  output logic [edfl_pkg::SIZE_W-1:0]       out_next_size,
  output logic [edfl_pkg::SYNC_W-1:0]       out_sync_state,
  output logic [edfl_pkg::ID_FIELD_W-1:0]   out_sync_id
);

  import edfl_pkg::*;

  localparam int ID_W  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int LD_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  logic [OP_W-1:0]       op_r;
  logic [ID_FIELD_W-1:0] id_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic                  a_cur_r;
  logic [CNT_W-1:0]      cnt_a_r;
  logic [CNT_W-1:0]      cnt_b_r;
  logic [ID_FIELD_W-1:0] first_a_r;
  logic [ID_FIELD_W-1:0] first_b_r;
  logic [STATUS_W-1:0]   status_r;
  logic [ID_FIELD_W-1:0] entry_r;
  logic [CNT_W-1:0]      idx_r;
  logic [ID_FIELD_W-1:0] cand_r;
  logic [ID_W-1:0]       clr_addr_r;
  logic                  need_clear_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [ID_FIELD_W-1:0] out_entry_r;
  logic [SIZE_W-1:0]     out_cur_size_r;
  logic [SIZE_W-1:0]     out_nxt_size_r;
  logic [SYNC_W-1:0]     out_sync_state_r;
  logic [ID_FIELD_W-1:0] out_sync_id_r;

  logic [ID_FIELD_W-1:0] id_rem;
  logic [CNT_W-1:0]      cur_cnt;
  logic [CNT_W-1:0]      nxt_cnt;
  logic [ID_FIELD_W-1:0] cur_first;
  logic [ID_FIELD_W-1:0] la_rdata;
  logic [ID_FIELD_W-1:0] lb_rdata;
  logic [ID_FIELD_W-1:0] cur_rdata;
  logic [ID_FIELD_W-1:0] nxt_rdata;
  logic [EPOCH_BITS-1:0] mark_rdata;
  logic [ID_FIELD_W-1:0] put_id;
  logic                  put_try;
  logic                  put_dup;
  logic                  put_full;
  logic                  put_ok;
  logic                  clr_last;
  logic                  rd_in_range;
  logic [EPOCH_BITS-1:0] epoch_inc;
  logic [LD_W-1:0]       list_raddr;
  logic [ID_W-1:0]       mark_raddr;
  logic                  mark_we;
  logic [ID_W-1:0]       mark_waddr;
  logic [EPOCH_BITS-1:0] mark_wdata;

  // id modulo ID_COUNT by conditional subtraction of shifted multiples
  always_comb begin
    id_rem = in_item_id;
    for (int k = ID_FIELD_W - 1; k >= 0; k--) begin
      if ((longint'(ID_COUNT) << k) < (longint'(1) << ID_FIELD_W)) begin
        if (longint'(id_rem) >= (longint'(ID_COUNT) << k)) begin
          id_rem = id_rem - ID_FIELD_W'(longint'(ID_COUNT) << k);
        end
      end
    end
  end

  assign cur_cnt   = a_cur_r ? cnt_a_r : cnt_b_r;
  assign nxt_cnt   = a_cur_r ? cnt_b_r : cnt_a_r;
  assign cur_first = a_cur_r ? first_a_r : first_b_r;
  assign cur_rdata = a_cur_r ? la_rdata : lb_rdata;
  assign nxt_rdata = a_cur_r ? lb_rdata : la_rdata;

  assign put_id   = cmd.rm_eval ? cand_r : id_r;
  assign put_try  = (cmd.eval && (op_r == OP_PUT)) || (cmd.rm_eval && (cand_r != id_r));
  assign put_dup  = (mark_rdata == epoch_r);
  assign put_full = (nxt_cnt == CNT_W'(LIST_DEPTH));
  assign put_ok   = put_try && !put_dup && !put_full;

  assign clr_last    = (clr_addr_r == ID_W'(ID_COUNT - 1));
  assign rd_in_range = 32'(slot_r) < 32'((op_r == OP_RD_CUR) ? cur_cnt : nxt_cnt);
  assign epoch_inc   = epoch_r + EPOCH_BITS'(1);

  assign list_raddr = cmd.rm_lread ? idx_r[LD_W-1:0] : LD_W'(in_slot);
  assign mark_raddr = cmd.rm_mread ? ID_W'(cur_rdata) : ID_W'(id_rem);
  assign mark_we    = put_ok || cmd.clr_step;
  assign mark_waddr = cmd.clr_step ? clr_addr_r : ID_W'(put_id);
  assign mark_wdata = cmd.clr_step ? '0 : epoch_r;

  edfl_ram #(.WIDTH(EPOCH_BITS), .DEPTH(ID_COUNT)) u_marks (
    .clk     (clk),
    .wr_en   (mark_we),
    .wr_addr (mark_waddr),
    .wr_data (mark_wdata),
    .rd_addr (mark_raddr),
    .rd_data (mark_rdata)
  );

  edfl_ram #(.WIDTH(ID_FIELD_W), .DEPTH(LIST_DEPTH)) u_list_a (
    .clk     (clk),
    .wr_en   (put_ok && !a_cur_r),
    .wr_addr (nxt_cnt[LD_W-1:0]),
    .wr_data (put_id),
    .rd_addr (list_raddr),
    .rd_data (la_rdata)
  );

  edfl_ram #(.WIDTH(ID_FIELD_W), .DEPTH(LIST_DEPTH)) u_list_b (
    .clk     (clk),
    .wr_en   (put_ok && a_cur_r),
    .wr_addr (nxt_cnt[LD_W-1:0]),
    .wr_data (put_id),
    .rd_addr (list_raddr),
    .rd_data (lb_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r      <= EPOCH_BITS'(2);
      a_cur_r      <= 1'b1;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      need_clear_r <= 1'b1;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        if (clr_last) begin
          clr_addr_r   <= '0;
          need_clear_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + ID_W'(1);
        end
      end
      if (put_ok) begin
        if (a_cur_r) begin
          cnt_b_r <= cnt_b_r + CNT_W'(1);
        end else begin
          cnt_a_r <= cnt_a_r + CNT_W'(1);
        end
      end
      if (cmd.swap) begin
        if (op_r == OP_RESET) begin
          // lists emptied, epoch restarts at one, then one swap
          epoch_r      <= EPOCH_BITS'(2);
          a_cur_r      <= 1'b0;
          cnt_a_r      <= '0;
          cnt_b_r      <= '0;
          need_clear_r <= 1'b1;
        end else begin
          if (epoch_inc == '0) begin
            epoch_r      <= EPOCH_BITS'(1);
            need_clear_r <= 1'b1;
          end else begin
            epoch_r <= epoch_inc;
          end
          a_cur_r <= !a_cur_r;
          if (a_cur_r) begin
            cnt_a_r <= '0;
          end else begin
            cnt_b_r <= '0;
          end
        end
      end
      if (cmd.resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      id_r     <= id_rem;
      slot_r   <= in_slot;
      status_r <= STS_DONE;
      entry_r  <= '0;
      idx_r    <= '0;
    end
    if (cmd.eval) begin
      if (op_r == OP_PUT) begin
        if (put_dup) begin
          status_r <= STS_DUP;
        end else if (put_full) begin
          status_r <= STS_FULL;
        end
      end else if ((op_r == OP_RD_CUR) || (op_r == OP_RD_NXT)) begin
        if (rd_in_range) begin
          entry_r <= (op_r == OP_RD_CUR) ? cur_rdata : nxt_rdata;
        end else begin
          status_r <= STS_RANGE;
        end
      end
    end
    if (cmd.rm_mread) begin
      cand_r <= cur_rdata;
    end
    if (cmd.rm_eval) begin
      if (put_try && !put_dup && put_full) begin
        status_r <= STS_FULL;
      end
      idx_r <= idx_r + CNT_W'(1);
    end
    if (put_ok && (nxt_cnt == '0)) begin
      if (a_cur_r) begin
        first_b_r <= put_id;
      end else begin
        first_a_r <= put_id;
      end
    end
    if (cmd.resp_load) begin
      out_status_r   <= status_r;
      out_entry_r    <= entry_r;
      out_cur_size_r <= SIZE_W'(cur_cnt);
      out_nxt_size_r <= SIZE_W'(nxt_cnt);
      if (cur_cnt == '0) begin
        out_sync_state_r <= SYNC_NONE;
        out_sync_id_r    <= '0;
      end else begin
        out_sync_state_r <= (cur_cnt == CNT_W'(1)) ? SYNC_SINGLE : SYNC_MULTI;
        out_sync_id_r    <= cur_first;
      end
    end
  end

  assign sts.cur_empty  = (cur_cnt == '0);
  assign sts.idx_last   = ((idx_r + CNT_W'(1)) == cur_cnt);
  assign sts.clr_last   = clr_last;
  assign sts.need_clear = need_clear_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_id     = out_entry_r;
  assign out_current_size = out_cur_size_r;
  assign out_next_size    = out_nxt_size_r;
  assign out_sync_state   = out_sync_state_r;
  assign out_sync_id      = out_sync_id_r;

endmodule

// ----- hdl/epoch_dedup_frontier_lists.sv -----
// Double-buffered frontier lists with epoch-stamped visited marks. One result
// item per input item. Put, read and swap pass through accept, evaluate
// against the registered memory read or swap, and load the result register;
// unused op codes pass through accept and load the result register. Remove
// passes through accept, then for each id of the current list a list read,
// a mark read and its put, then swap and load. Any op waits in the load
// cycle while the previous result is still held by out_ready low. After reset,
// after a reset op and after an epoch wrap the mark memory is cleared one
// entry per cycle, with no item accepted during the sweep. A new item is
// accepted while the previous result still waits on the output.
// Depends on edfl_pkg, edfl_ctrl, edfl_dp and edfl_ram.
module epoch_dedup_frontier_lists #(
  parameter int ID_COUNT   = 4096,
  parameter int LIST_DEPTH = 256,
  parameter int EPOCH_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [edfl_pkg::OP_W-1:0]         in_op,
  input  logic [edfl_pkg::ID_FIELD_W-1:0]   in_item_id,
  input  logic [edfl_pkg::SLOT_W-1:0]       in_slot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [edfl_pkg::STATUS_W-1:0]     out_status,
  output logic [edfl_pkg::ID_FIELD_W-1:0]   out_entry_id,
  output logic [edfl_pkg::SIZE_W-1:0]       out_current_size,
  output logic [edfl_pkg::SIZE_W-1:0]       out_next_size,
  output logic [edfl_pkg::SYNC_W-1:0]       out_sync_state,
  output logic [edfl_pkg::ID_FIELD_W-1:0]   out_sync_id
);

  import edfl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  edfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  edfl_dp #(
    .ID_COUNT   (ID_COUNT),
    .LIST_DEPTH (LIST_DEPTH),
    .EPOCH_BITS (EPOCH_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_item_id       (in_item_id),
    .in_slot          (in_slot),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_id     (out_entry_id),
    .out_current_size (out_current_size),
    .out_next_size    (out_next_size),
    .out_sync_state   (out_sync_state),
    .out_sync_id      (out_sync_id)
  );

endmodule

// ----- test/epoch_dedup_frontier_lists_tb.sv -----
// Self-checking testbench for epoch_dedup_frontier_lists: queued stimulus, a
// valid/ready driver and monitor, and an in-line predictor of lists and marks.
// Depends on edfl_pkg and the epoch_dedup_frontier_lists RTL only.
module epoch_dedup_frontier_lists_tb;
  import edfl_pkg::*;

  localparam int IDS     = 4096;
  localparam int DEPTH   = 256;
  localparam int EPOCH_W = 8;
  localparam int ITEMS   = 1550;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [ID_FIELD_W-1:0] item_id;
    logic [SLOT_W-1:0]     slot;
  } frontier_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ID_FIELD_W-1:0] entry_id;
    logic [SIZE_W-1:0]     cur_size;
    logic [SIZE_W-1:0]     nxt_size;
    logic [SYNC_W-1:0]     sync_state;
    logic [ID_FIELD_W-1:0] sync_id;
  } frontier_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op      = '0;
  logic [ID_FIELD_W-1:0] in_item_id = '0;
  logic [SLOT_W-1:0]     in_slot    = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ID_FIELD_W-1:0] out_entry_id;
  logic [SIZE_W-1:0]     out_current_size;
  logic [SIZE_W-1:0]     out_next_size;
  logic [SYNC_W-1:0]     out_sync_state;
  logic [ID_FIELD_W-1:0] out_sync_id;

  epoch_dedup_frontier_lists #(
    .ID_COUNT(IDS),
    .LIST_DEPTH(DEPTH),
    .EPOCH_BITS(EPOCH_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_item_id(in_item_id),
    .in_slot(in_slot),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_entry_id(out_entry_id),
    .out_current_size(out_current_size),
    .out_next_size(out_next_size),
    .out_sync_state(out_sync_state),
    .out_sync_id(out_sync_id)
  );

  always #5 clk = ~clk;

  frontier_cmd_t    pending_cmds[$];
  frontier_result_t expected_results[$];
  int unsigned      round_ids[$];
  int unsigned      prev_ids[$];

  int total_items  = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int epoch_wraps  = 0;
  int op_seen[8];
  int status_seen[4];
  logic in_taken   = 1'b0;
  int hold_left    = 0;
  int holds_done   = 0;

  // predicted block state
  logic [EPOCH_W-1:0]    visit_stamp[IDS];
  logic [EPOCH_W-1:0]    frontier_epoch = EPOCH_W'(2);
  logic [ID_FIELD_W-1:0] frontier_ids[2][DEPTH];
  int unsigned           frontier_len[2] = '{0, 0};
  int unsigned           cur_side = 0;

  function automatic logic [STATUS_W-1:0] visit_and_append(int unsigned id);
    int unsigned nxt;
    nxt = 1 - cur_side;
    if (visit_stamp[id] == frontier_epoch) return STS_DUP;
    if (frontier_len[nxt] >= DEPTH) return STS_FULL;
    frontier_ids[nxt][frontier_len[nxt]] = id[ID_FIELD_W-1:0];
    frontier_len[nxt]++;
    visit_stamp[id] = frontier_epoch;
    return STS_DONE;
  endfunction

  function automatic void advance_epoch();
    frontier_epoch = frontier_epoch + 1'b1;
    if (frontier_epoch == '0) begin
      foreach (visit_stamp[i]) visit_stamp[i] = '0;
      frontier_epoch = EPOCH_W'(1);
      epoch_wraps++;
    end
    cur_side = 1 - cur_side;
    frontier_len[1 - cur_side] = 0;
  endfunction

  function automatic frontier_result_t predict_frontier(logic [OP_W-1:0] op,
                                                        logic [ID_FIELD_W-1:0] raw_id,
                                                        logic [SLOT_W-1:0] slot);
    frontier_result_t r;
    int unsigned id, n, side;
    r = '0;
    id = raw_id % IDS;
    case (op)
      OP_PUT: r.status = visit_and_append(id);
      OP_SWAP: advance_epoch();
      OP_REMOVE: begin
        n = frontier_len[cur_side];
        for (int i = 0; i < n; i++) begin
          if (frontier_ids[cur_side][i] != id) begin
            if (visit_and_append(frontier_ids[cur_side][i]) == STS_FULL) r.status = STS_FULL;
          end
        end
        advance_epoch();
      end
      OP_RD_CUR, OP_RD_NXT: begin
        side = (op == OP_RD_CUR) ? cur_side : 1 - cur_side;
        if (slot < frontier_len[side]) r.entry_id = frontier_ids[side][slot];
        else r.status = STS_RANGE;
      end
      OP_RESET: begin
        foreach (visit_stamp[i]) visit_stamp[i] = '0;
        frontier_len[0] = 0;
        frontier_len[1] = 0;
        cur_side = 0;
        frontier_epoch = EPOCH_W'(1);
        advance_epoch();
      end
      default: ;
    endcase
    r.cur_size = SIZE_W'(frontier_len[cur_side]);
    r.nxt_size = SIZE_W'(frontier_len[1 - cur_side]);
    if (frontier_len[cur_side] == 0) begin
      r.sync_state = SYNC_NONE;
    end else begin
      r.sync_state = (frontier_len[cur_side] == 1) ? SYNC_SINGLE : SYNC_MULTI;
      r.sync_id = frontier_ids[cur_side][0];
    end
    op_seen[op]++;
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic queue_cmd(logic [OP_W-1:0] op, int unsigned id, int unsigned slot);
    frontier_cmd_t c;
    c.op = op;
    c.item_id = id[ID_FIELD_W-1:0];
    c.slot = slot[SLOT_W-1:0];
    pending_cmds = {pending_cmds, c};
  endtask

  // puts (some repeated), reads and spare ops, closed by a swap, remove or reset
  task automatic queue_general_round();
    int unsigned n_items, pick, id, slot;
    n_items = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    prev_ids = round_ids;
    round_ids.delete();
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if (round_ids.size() != 0 && $urandom_range(0, 3) == 0)
          id = round_ids[$urandom_range(0, round_ids.size() - 1)];
        else if (prev_ids.size() != 0 && $urandom_range(0, 4) == 0)
          id = prev_ids[$urandom_range(0, prev_ids.size() - 1)];
        else
          id = $urandom_range(0, IDS - 1);
        round_ids = {round_ids, id};
        queue_cmd(OP_PUT, id, $urandom_range(0, DEPTH - 1));
      end else if (pick < 90) begin
        slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEPTH - 1)
             : $urandom_range(0, round_ids.size() + prev_ids.size() + 1);
        queue_cmd($urandom_range(0, 1) ? OP_RD_CUR : OP_RD_NXT, $urandom_range(0, IDS - 1),
                  slot);
      end else begin
        queue_cmd($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI), $urandom_range(0, IDS - 1),
                  $urandom_range(0, DEPTH - 1));
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      queue_cmd(OP_SWAP, $urandom_range(0, IDS - 1), $urandom_range(0, DEPTH - 1));
    end else if (pick < 95) begin
      id = (prev_ids.size() != 0 && $urandom_range(0, 9) < 7)
         ? prev_ids[$urandom_range(0, prev_ids.size() - 1)] : $urandom_range(0, IDS - 1);
      queue_cmd(OP_REMOVE, id, $urandom_range(0, DEPTH - 1));
    end else begin
      queue_cmd(OP_RESET, $urandom_range(0, IDS - 1), $urandom_range(0, DEPTH - 1));
    end
  endtask

  function automatic int idle_pct(bit for_sink);
    int phase;
    phase = (total_items == 0) ? 2 : items_sent * 3 / total_items;
    if (phase == 0) return for_sink ? 46 : 33;
    if (phase == 1) return for_sink ? 33 : 46;
    return 0;
  endfunction

  always @(negedge clk) begin : source
    frontier_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        cmd = pending_cmds.pop_front();
        in_valid   <= 1'b1;
        in_op      <= cmd.op;
        in_item_id <= cmd.item_id;
        in_slot    <= cmd.slot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-offs, one after each of the first three quarters of the results
  always @(negedge clk) begin : hold_ctl
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 3 && total_items != 0 &&
                 results_seen >= (holds_done + 1) * total_items / 4) begin
      hold_left  <= 300;
      holds_done <= holds_done + 1;
    end
  end

  always @(negedge clk) begin : sink
    if (!rst_n || hold_left > 0) out_ready <= 1'b0;
    else out_ready <= $urandom_range(0, 99) >= idle_pct(1'b1);
  end

  always @(posedge clk) begin : monitor
    frontier_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("status", out_status, want.status);
          check_field("entry_id", out_entry_id, want.entry_id);
          check_field("current_size", out_current_size, want.cur_size);
          check_field("next_size", out_next_size, want.nxt_size);
          check_field("sync_state", out_sync_state, want.sync_state);
          check_field("sync_id", out_sync_id, want.sync_id);
        end
      end
      if (in_valid && in_ready) begin
        expected_results = {expected_results, predict_frontier(in_op, in_item_id, in_slot)};
        items_sent++;
      end
    end
    in_taken <= in_valid && in_ready;
  end

  initial begin : stimulus
    int unsigned base;
    foreach (visit_stamp[i]) visit_stamp[i] = '0;

    // directed: empty reads, id extremes, duplicates, remove, spare ops, reset
    queue_cmd(OP_RD_CUR, 0, 0);
    queue_cmd(OP_RD_NXT, IDS - 1, DEPTH - 1);
    queue_cmd(OP_PUT, 0, 0);
    queue_cmd(OP_PUT, IDS - 1, 0);
    queue_cmd(OP_PUT, IDS - 1, 0);
    queue_cmd(OP_PUT, 12'hAAA, 0);
    queue_cmd(OP_PUT, 12'h555, 0);
    queue_cmd(OP_RD_NXT, 0, 0);
    queue_cmd(OP_RD_NXT, 0, 3);
    queue_cmd(OP_RD_NXT, 0, 4);
    queue_cmd(OP_SWAP, 0, 0);
    queue_cmd(OP_RD_CUR, 0, 1);
    queue_cmd(OP_RD_CUR, 0, 0);
    queue_cmd(OP_PUT, 0, 0);
    queue_cmd(OP_PUT, 12'h555, 0);
    queue_cmd(OP_REMOVE, IDS - 1, 0);
    queue_cmd(OP_RD_CUR, 0, 2);
    queue_cmd(OP_UNUSED_LO, IDS - 1, DEPTH - 1);
    queue_cmd(OP_UNUSED_HI, 12'h3C3, 8'h5A);
    queue_cmd(OP_RESET, 0, 0);
    queue_cmd(OP_REMOVE, 12'h001, 0);
    queue_cmd(OP_RD_CUR, 0, 0);

    while (pending_cmds.size() < 320) queue_general_round();

    // fill the next list past its depth, then remove with and without overflow
    base = $urandom_range(0, IDS - 1);
    for (int k = 0; k < DEPTH + 12; k++) begin
      queue_cmd(OP_PUT, (base + k) % IDS, $urandom_range(0, DEPTH - 1));
      if (k % 64 == 5) queue_cmd(OP_PUT, (base + k - 3) % IDS, 0);
    end
    queue_cmd(OP_RD_NXT, 0, DEPTH - 1);
    queue_cmd(OP_RD_NXT, 0, 0);
    queue_cmd(OP_SWAP, 0, 0);
    queue_cmd(OP_RD_CUR, 0, DEPTH - 1);
    queue_cmd(OP_REMOVE, (base + 7) % IDS, 0);
    queue_cmd(OP_RD_CUR, 0, DEPTH - 1);
    for (int k = 0; k < 6; k++) queue_cmd(OP_PUT, $urandom_range(0, IDS - 1), 0);
    queue_cmd(OP_REMOVE, $urandom_range(0, IDS - 1), 0);
    queue_cmd(OP_RD_CUR, 0, DEPTH - 2);

    // two epoch wraps; ids stamped before the first wrap return at the same epoch
    queue_cmd(OP_RESET, 0, 0);
    base = $urandom_range(0, IDS - 1);
    for (int r = 0; r < 512; r++) begin
      if (r % 3 == 0) queue_cmd(OP_PUT, (base + r % 255) % IDS, $urandom_range(0, DEPTH - 1));
      if ($urandom_range(0, 19) == 0)
        queue_cmd(OP_RD_CUR, $urandom_range(0, IDS - 1), $urandom_range(0, 1));
      queue_cmd(OP_SWAP, $urandom_range(0, IDS - 1), $urandom_range(0, DEPTH - 1));
    end

    while (pending_cmds.size() < ITEMS) queue_general_round();
    total_items = pending_cmds.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_sent < total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("covered %0d items: %0d puts, %0d swaps, %0d removes, %0d reads, %0d resets, %0d spare",
             items_sent, op_seen[OP_PUT], op_seen[OP_SWAP], op_seen[OP_REMOVE],
             op_seen[OP_RD_CUR] + op_seen[OP_RD_NXT], op_seen[OP_RESET],
             op_seen[OP_UNUSED_LO] + op_seen[OP_UNUSED_HI]);
    $display("%0d results: %0d dup, %0d out of range, %0d full; %0d epoch wraps; %0d mismatches",
             results_seen, status_seen[STS_DUP], status_seen[STS_RANGE], status_seen[STS_FULL],
             epoch_wraps, mismatches);
    if (mismatches == 0) begin
      $display("epoch_dedup_frontier_lists regression: pass");
    end else begin
      $display("epoch_dedup_frontier_lists regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("epoch_dedup_frontier_lists regression: fail");
    $finish;
  end

endmodule

// ----- epoch_dedup_frontier_lists.f -----
hdl/edfl_pkg.sv
hdl/edfl_ram.sv
hdl/edfl_ctrl.sv
hdl/edfl_dp.sv
hdl/epoch_dedup_frontier_lists.sv
test/epoch_dedup_frontier_lists_tb.sv
